// ===== hdl/interleaved_multi_producer_ring_assert.svh =====
// ---------------------------------------------------------------------------
// interleaved_multi_producer_ring assertion macros
// shared concurrent assertion forms, compiled out when ASSERT_OFF is set
// ---------------------------------------------------------------------------
`ifndef INTERLEAVED_MULTI_PRODUCER_RING_ASSERT_SVH
`define INTERLEAVED_MULTI_PRODUCER_RING_ASSERT_SVH

`ifndef ASSERT_OFF
// consequence holds in the same cycle as the antecedent
`define IMPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// consequence holds in the cycle after the antecedent
`define IMPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IMPR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define IMPR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/impr_pkg.sv =====
// ---------------------------------------------------------------------------
// impr_pkg
// operation and status codes and the store control type for the ring
// ---------------------------------------------------------------------------
`default_nettype none

package impr_pkg;

    // operation codes
    localparam logic [1:0] FN_PUSH  = 2'd0;
    localparam logic [1:0] FN_POP   = 2'd1;
    localparam logic [1:0] FN_CLEAR = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE         = 2'd0;
    localparam logic [1:0] ST_OCCUPIED     = 2'd1;
    localparam logic [1:0] ST_EMPTY        = 2'd2;
    localparam logic [1:0] ST_BAD_PRODUCER = 2'd3;

    // control from the ring logic to the payload store
    typedef struct packed {
        logic wr;
        logic clr;
    } t_mem_ctl;

endpackage

`default_nettype wire

// ===== hdl/impr_payload_store.sv =====
// ---------------------------------------------------------------------------
// impr_payload_store
// slot payload memory with one write and one registered read port; per-slot
// valid bits let a clear zero every payload
// ---------------------------------------------------------------------------
`default_nettype none

module impr_payload_store
    import impr_pkg::*;
#(
    parameter int SLOTS        = 16,
    parameter int PAYLOAD_BITS = 32,
    localparam int SW          = $clog2(SLOTS)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_mem_ctl                i_ctl,
    input  wire logic [SW-1:0]           i_wr_addr,
    input  wire logic [PAYLOAD_BITS-1:0] i_wr_data,
    input  wire logic [SW-1:0]           i_rd_addr,
    output logic      [PAYLOAD_BITS-1:0] o_rd_data
);

    logic [PAYLOAD_BITS-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0]        r_valid;
    logic [PAYLOAD_BITS-1:0] r_rd_data;
    logic                    r_rd_valid;

    // payload memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // valid bits: an entry that is not valid reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_rd_addr];
            if (i_ctl.clr) begin
                r_valid <= '0;
            end else if (i_ctl.wr) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

// ===== hdl/interleaved_multi_producer_ring.sv =====
// o_done with the item's result is registered and rises in the cycle after an accepted start.
// Throughput: one item per cycle while busy is low; every push or pop touches one
// slot flag, one pointer and one port of the payload memory.
// The receiver cannot stall, so busy is high only during reset and the cycle after.
// Reset (i_rst_n low, synchronous): flags, payload valid bits and consumer
// pointer clear, producer pointer i loads i mod SLOTS, stride loads 5.
// ---------------------------------------------------------------------------
// interleaved_multi_producer_ring
// slot ring shared by interleaved producers and one in-order consumer
// ---------------------------------------------------------------------------
`default_nettype none

`include "interleaved_multi_producer_ring_assert.svh"

module interleaved_multi_producer_ring
    import impr_pkg::*;
#(
    parameter int SLOTS         = 16,
    parameter int MAX_PRODUCERS = 8,
    parameter int PAYLOAD_BITS  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_data,
    // command side
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_func,
    input  wire logic [2:0]  i_producer_id,
    input  wire logic [31:0] i_payload_in,
    // result side
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [31:0]      o_payload_out,
    output logic [3:0]       o_slot_used
);

    localparam int SW = $clog2(SLOTS);
    localparam int PW = (MAX_PRODUCERS > 1) ? $clog2(MAX_PRODUCERS) : 1;

    // clamp a raw producer count to 1 .. MAX_PRODUCERS
    function automatic logic [3:0] clamp_stride(input logic [3:0] n);
        logic [3:0] s;
        s = n;
        if (s == 4'd0) begin
            s = 4'd1;
        end
        if (32'(s) > MAX_PRODUCERS) begin
            s = 4'(MAX_PRODUCERS);
        end
        return s;
    endfunction

    // reduce a stride below SLOTS, at most seven subtractions
    function automatic logic [SW-1:0] stride_mod(input logic [3:0] s);
        logic [4:0] v;
        v = {1'b0, s};
        for (int k = 0; k < 8; k++) begin
            if (32'(v) >= SLOTS) begin
                v = v - 5'(SLOTS);
            end
        end
        return SW'(v);
    endfunction

    logic [3:0]    r_stride;
    logic [SW-1:0] r_stride_mod;
    logic          r_busy;
    logic [SLOTS-1:0] r_full;
    logic [SW-1:0] r_ptr [MAX_PRODUCERS];
    logic [SW-1:0] r_cons;
    logic          r_done;
    logic [1:0]    r_status;
    logic [SW-1:0] r_slot;
    logic          r_pop_ok;

    logic          accept;
    logic          is_push;
    logic          is_pop;
    logic          is_clear;
    logic          pid_bad;
    logic [PW-1:0] pid_idx;
    logic [SW-1:0] push_slot;
    logic          push_ok;
    logic          pop_ok;
    logic [SW:0]   ptr_sum;
    logic [SW-1:0] n_ptr;
    logic [SW-1:0] n_cons;
    logic [1:0]    n_status;
    logic [SW-1:0] n_slot;
    t_mem_ctl      mem_ctl;
    logic [PAYLOAD_BITS-1:0] rd_data;

    // config register: stride and its value reduced mod SLOTS
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride     <= clamp_stride(4'd5);
            r_stride_mod <= stride_mod(clamp_stride(4'd5));
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_stride     <= clamp_stride(i_cfg_data);
            r_stride_mod <= stride_mod(clamp_stride(i_cfg_data));
        end
    end

    assign o_cfg_ready = ~r_busy;
    assign busy        = r_busy;

    // decode the accepted item
    assign accept   = start && !r_busy;
    assign is_push  = accept && (i_func == FN_PUSH);
    assign is_pop   = accept && (i_func == FN_POP);
    assign is_clear = accept && (i_func == FN_CLEAR);

    assign pid_bad   = ({1'b0, i_producer_id} >= r_stride);
    assign pid_idx   = PW'(i_producer_id);
    assign push_slot = r_ptr[pid_idx];
    assign push_ok   = is_push && !pid_bad && !r_full[push_slot];
    assign pop_ok    = is_pop && r_full[r_cons];

    // pointer advance with wrap
    always_comb begin
        ptr_sum = {1'b0, push_slot} + {1'b0, r_stride_mod};
        if (32'(ptr_sum) >= SLOTS) begin
            ptr_sum = ptr_sum - (SW+1)'(SLOTS);
        end
        n_ptr  = SW'(ptr_sum);
        n_cons = (32'(r_cons) == SLOTS - 1) ? '0 : r_cons + SW'(1);
    end

    // result status and addressed slot
    always_comb begin
        n_status = ST_DONE;
        n_slot   = '0;
        case (i_func)
            FN_PUSH: begin
                if (pid_bad) begin
                    n_status = ST_BAD_PRODUCER;
                end else begin
                    n_slot = push_slot;
                    if (r_full[push_slot]) begin
                        n_status = ST_OCCUPIED;
                    end
                end
            end
            FN_POP: begin
                n_slot = r_cons;
                if (!r_full[r_cons]) begin
                    n_status = ST_EMPTY;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // ring state: flags and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_full <= '0;
            r_cons <= '0;
            for (int i = 0; i < MAX_PRODUCERS; i++) begin
                r_ptr[i] <= SW'(i % SLOTS);
            end
        end else begin
            r_busy <= 1'b0;
            if (push_ok) begin
                r_full[push_slot] <= 1'b1;
                r_ptr[pid_idx]    <= n_ptr;
            end
            if (pop_ok) begin
                r_full[r_cons] <= 1'b0;
                r_cons         <= n_cons;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_slot   <= n_slot;
        r_pop_ok <= pop_ok;
    end

    // payload store
    assign mem_ctl.wr  = push_ok;
    assign mem_ctl.clr = is_clear;

    impr_payload_store #(
        .SLOTS        (SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_wr_addr (push_slot),
        .i_wr_data (PAYLOAD_BITS'(i_payload_in)),
        .i_rd_addr (r_cons),
        .o_rd_data (rd_data)
    );

    // result ports
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_slot_used   = 4'(r_slot);
    assign o_payload_out = r_pop_ok ? 32'(rd_data) : 32'd0;

    // checks
    `IMPR_ASSERT_NEXT(a_done_follows_accept, i_clk, i_rst_n, accept, r_done)
    `IMPR_ASSERT_NEXT(a_no_done_without_accept, i_clk, i_rst_n, !accept, !r_done)
    `IMPR_ASSERT_NEXT(a_pop_clears_flag, i_clk, i_rst_n, pop_ok, !r_full[$past(r_cons)])
    `IMPR_ASSERT_NEXT(a_cons_moves_on_pop, i_clk, i_rst_n, !pop_ok, $stable(r_cons))
    `IMPR_ASSERT_NOW(a_bad_slot_zero, i_clk, i_rst_n, r_done && (r_status == ST_BAD_PRODUCER), r_slot == '0)

endmodule

`default_nettype wire
